// ===== hw/rtl/lhps_pkg.sv =====
// Package for the lane histogram peak steering core.
// Holds the register file struct, the result item layout and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package lhps_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_FRAME_WIDTH        = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT       = 3'd1;
    localparam logic [2:0] REG_ROI_TOP_ROW        = 3'd2;
    localparam logic [2:0] REG_LEFT_SEARCH_END    = 3'd3;
    localparam logic [2:0] REG_RIGHT_SEARCH_START = 3'd4;
    localparam logic [2:0] REG_FRAME_CENTER       = 3'd5;
    localparam logic [2:0] REG_NEAR_STEP          = 3'd6;
    localparam logic [2:0] REG_FAR_STEP           = 3'd7;

    localparam int CFG_DATA_W = 10;

    // Steering codes.
    localparam logic [2:0] STEER_STRAIGHT = 3'd0;
    localparam logic [2:0] STEER_RIGHT_1  = 3'd1;
    localparam logic [2:0] STEER_RIGHT_2  = 3'd2;
    localparam logic [2:0] STEER_RIGHT_3  = 3'd3;
    localparam logic [2:0] STEER_LEFT_1   = 3'd4;
    localparam logic [2:0] STEER_LEFT_2   = 3'd5;
    localparam logic [2:0] STEER_LEFT_3   = 3'd6;

    // Output queue depth and pointer width.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [9:0] frame_width;
        logic [8:0] frame_height;
        logic [7:0] roi_top_row;
        logic [9:0] left_search_end;
        logic [8:0] right_search_start;
        logic [8:0] frame_center;
        logic [8:0] near_step;
        logic [8:0] far_step;
    } cfg_t;

    // Packed so that left_lane_column sits in the lowest bits.
    typedef struct packed {
        logic [2:0]        steer_code;
        logic signed [9:0] center_offset;
        logic [8:0]        lane_center_column;
        logic [8:0]        right_lane_column;
        logic [8:0]        left_lane_column;
    } result_t;

endpackage

// ===== hw/rtl/lhps_config.sv =====
// Configuration register file for the lane histogram peak steering core.
// Depends on lhps_pkg.
`timescale 1ns / 1ps

module lhps_config
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [lhps_pkg::CFG_DATA_W-1:0] cfg_data,
    output lhps_pkg::cfg_t                  cfg
);

    lhps_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width        <= 10'd400;
            cfg_reg.frame_height       <= 9'd240;
            cfg_reg.roi_top_row        <= 8'd140;
            cfg_reg.left_search_end    <= 10'd180;
            cfg_reg.right_search_start <= 9'd220;
            cfg_reg.frame_center       <= 9'd200;
            cfg_reg.near_step          <= 9'd5;
            cfg_reg.far_step           <= 9'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lhps_pkg::REG_FRAME_WIDTH:        cfg_reg.frame_width        <= cfg_data;
                lhps_pkg::REG_FRAME_HEIGHT:       cfg_reg.frame_height       <= cfg_data[8:0];
                lhps_pkg::REG_ROI_TOP_ROW:        cfg_reg.roi_top_row        <= cfg_data[7:0];
                lhps_pkg::REG_LEFT_SEARCH_END:    cfg_reg.left_search_end    <= cfg_data;
                lhps_pkg::REG_RIGHT_SEARCH_START: cfg_reg.right_search_start <= cfg_data[8:0];
                lhps_pkg::REG_FRAME_CENTER:       cfg_reg.frame_center       <= cfg_data[8:0];
                lhps_pkg::REG_NEAR_STEP:          cfg_reg.near_step          <= cfg_data[8:0];
                lhps_pkg::REG_FAR_STEP:           cfg_reg.far_step           <= cfg_data[8:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/lhps_hist_mem.sv =====
// Column histogram memory: one write port, one registered read port.
// A read that hits the address written in the same cycle returns the new count.
// Clears itself after reset, one entry per cycle. Depends on no package.
`timescale 1ns / 1ps

module lhps_hist_mem
#(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    output logic              busy
);

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= 8'd0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

// ===== hw/rtl/lhps_result.sv =====
// Result stage: registers the lane centre and offset; the steering grade is decoded combinationally from them.
// Depends on lhps_pkg.
`timescale 1ns / 1ps

module lhps_result
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [8:0]        left_col,
    input  logic [8:0]        right_col,
    input  logic [8:0]        frame_center,
    input  logic [8:0]        near_step,
    input  logic [8:0]        far_step,
    output logic              res_valid,
    output lhps_pkg::result_t res
);

    logic              q_valid_reg;
    logic [8:0]        q_left_reg;
    logic [8:0]        q_right_reg;
    logic [8:0]        q_center_reg;
    logic signed [9:0] q_offset_reg;

    logic [9:0]        pair_sum;
    logic [10:0]       diff;
    logic [9:0]        mag_full;
    logic [8:0]        mag;
    logic [2:0]        code;

    always_comb
    begin
        pair_sum = {1'b0, left_col} + {1'b0, right_col};
        diff     = {2'b00, pair_sum[9:1]} - {2'b00, frame_center};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_left_reg   <= left_col;
            q_right_reg  <= right_col;
            q_center_reg <= pair_sum[9:1];
            q_offset_reg <= diff[9:0];
        end
    end

    always_comb
    begin
        mag_full = q_offset_reg[9] ? (10'd0 - q_offset_reg) : q_offset_reg;
        mag      = mag_full[8:0];
        if (q_offset_reg == 10'sd0)
        begin
            code = lhps_pkg::STEER_STRAIGHT;
        end
        else if (!q_offset_reg[9])
        begin
            priority if (mag < near_step)
                code = lhps_pkg::STEER_RIGHT_1;
            else if (mag < far_step)
                code = lhps_pkg::STEER_RIGHT_2;
            else
                code = lhps_pkg::STEER_RIGHT_3;
        end
        else
        begin
            priority if (mag < near_step)
                code = lhps_pkg::STEER_LEFT_1;
            else if (mag < far_step)
                code = lhps_pkg::STEER_LEFT_2;
            else
                code = lhps_pkg::STEER_LEFT_3;
        end
    end

    assign res_valid              = q_valid_reg;
    assign res.left_lane_column   = q_left_reg;
    assign res.right_lane_column  = q_right_reg;
    assign res.lane_center_column = q_center_reg;
    assign res.center_offset      = q_offset_reg;
    assign res.steer_code         = code;

endmodule

// ===== hw/rtl/lhps_out_fifo.sv =====
// Output queue of result items between the result stages and the output channel.
// Depends on lhps_pkg.
`timescale 1ns / 1ps

module lhps_out_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lhps_pkg::result_t push_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lhps_pkg::result_t out_data
);

    lhps_pkg::result_t                entries [lhps_pkg::FIFO_DEPTH];
    logic [lhps_pkg::FIFO_PTR_W:0]    wr_ptr_reg;
    logic [lhps_pkg::FIFO_PTR_W:0]    rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_valid && out_ready)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg[lhps_pkg::FIFO_PTR_W-1:0]] <= push_data;
        end
    end

    assign out_valid = (wr_ptr_reg != rd_ptr_reg);
    assign out_data  = entries[rd_ptr_reg[lhps_pkg::FIFO_PTR_W-1:0]];

endmodule

// ===== hw/rtl/lane_histogram_peak_steering_core.sv =====
// Top level of the lane histogram peak steering core.
// Depends on lhps_pkg, lhps_config, lhps_hist_mem, lhps_result and lhps_out_fifo.
`timescale 1ns / 1ps

// Takes one pixel item per clock cycle while s_tready is high, in raster order, and gives
// one result item on the last pixel of each frame. After reset the histogram memory is
// cleared, during which s_tready stays low; configuration writes are taken throughout.
// A pixel passes a read stage and an update stage around the histogram memory, which
// has one read and one write port; a frame's peaks then pass the peak registers and the
// result stage into the output queue. Up to eight result items are queued; apart from
// the clearing after reset, input is held off only when that queue and the stages
// before it could hold no more.

module lane_histogram_peak_steering_core
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Pixel items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] pixel_on
    input  logic        s_tuser,   // [0] frame_start
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [8:0] left_lane_column, [17:9] right_lane_column,
                                   // [26:18] lane_center_column, [36:27] center_offset,
                                   // [39:37] steer_code
    // Configuration.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XW    = ((COL_W > 10) ? COL_W : 10) + 1;
    localparam int RW    = ((ROW_W > 9) ? ROW_W : 9) + 1;
    localparam int OUT_W = $clog2(lhps_pkg::FIFO_DEPTH + 1);

    lhps_pkg::cfg_t    cfg;
    lhps_pkg::result_t res;
    lhps_pkg::result_t out_item;
    logic              res_valid;

    // Position state.
    logic [COL_W-1:0] col_pos_reg;
    logic [ROW_W-1:0] row_pos_reg;

    // Accept-side decode.
    logic             accept;
    logic [COL_W-1:0] cp;
    logic [ROW_W-1:0] rp;
    logic [XW-1:0]    fw_x;
    logic [RW-1:0]    fh_x;
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] top;
    logic             last_row;
    logic             last_col;
    logic             emit;

    // Update stage.
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_pix_reg;
    logic             s1_first_reg;
    logic             s1_in_roi_reg;
    logic             s1_last_row_reg;
    logic             s1_emit_reg;

    logic [7:0]       hist_old;
    logic [8:0]       hist_sum;
    logic [7:0]       hist_new;
    logic             hist_we;
    logic             mem_busy;

    logic [7:0]       left_cnt_reg;
    logic [8:0]       left_col_reg;
    logic [7:0]       right_cnt_reg;
    logic [8:0]       right_col_reg;
    logic [7:0]       lb_cnt;
    logic [8:0]       lb_col;
    logic [7:0]       rb_cnt;
    logic [8:0]       rb_col;
    logic [XW-1:0]    s1_col_x;
    logic             left_hit;
    logic             right_hit;
    logic             col_zero;

    logic             p_valid_reg;
    logic [OUT_W-1:0] outstanding_reg;
    logic             out_pop;

    lhps_config u_config
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Frame geometry, clamped to the histogram size and the row counter.
    always_comb
    begin
        fw_x = XW'(cfg.frame_width);
        fh_x = RW'(cfg.frame_height);
        priority if (fw_x == '0)
            wm1 = '0;
        else if (fw_x > XW'(MAX_WIDTH))
            wm1 = COL_W'(MAX_WIDTH - 1);
        else
            wm1 = COL_W'(fw_x - 1'b1);
        priority if (fh_x == '0)
            hm1 = '0;
        else if (fh_x > RW'(MAX_HEIGHT))
            hm1 = ROW_W'(MAX_HEIGHT - 1);
        else
            hm1 = ROW_W'(fh_x - 1'b1);

        cp = s_tuser ? '0 : col_pos_reg;
        rp = s_tuser ? '0 : row_pos_reg;
        col = (cp > wm1) ? wm1 : cp;
        row = (rp > hm1) ? hm1 : rp;
        top = (RW'(cfg.roi_top_row) > RW'(hm1)) ? hm1 : ROW_W'(cfg.roi_top_row);
        last_row = (row == hm1);
        last_col = (col == wm1);
        emit     = last_row && last_col;
    end

    assign s_tready = !mem_busy && (outstanding_reg < OUT_W'(lhps_pkg::FIFO_DEPTH));
    assign accept   = s_tvalid && s_tready;
    assign out_pop  = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg     <= '0;
            row_pos_reg     <= '0;
            s1_valid_reg    <= 1'b0;
            p_valid_reg     <= 1'b0;
            outstanding_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            p_valid_reg  <= s1_valid_reg && s1_emit_reg;
            if (accept)
            begin
                if (last_col)
                begin
                    col_pos_reg <= '0;
                    row_pos_reg <= last_row ? '0 : row + 1'b1;
                end
                else
                begin
                    col_pos_reg <= col + 1'b1;
                    row_pos_reg <= row;
                end
            end
            // Count of result items in the stages and the queue.
            if ((accept && emit) && !out_pop)
                outstanding_reg <= outstanding_reg + 1'b1;
            else if (!(accept && emit) && out_pop)
                outstanding_reg <= outstanding_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg      <= col;
            s1_pix_reg      <= s_tdata[0];
            s1_first_reg    <= (row == top);
            s1_in_roi_reg   <= (row >= top);
            s1_last_row_reg <= last_row;
            s1_emit_reg     <= emit;
        end
    end

    lhps_hist_mem
    #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    )
    u_hist_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (hist_old),
        .wr_en   (hist_we),
        .wr_addr (s1_col_reg),
        .wr_data (hist_new),
        .busy    (mem_busy)
    );

    // Count update and peak tracking for the item read in the previous cycle.
    always_comb
    begin
        hist_sum = {1'b0, hist_old} + {8'd0, s1_pix_reg};
        if (s1_first_reg)
            hist_new = {7'd0, s1_pix_reg};
        else if (hist_old == lhps_pkg::COUNT_MAX)
            hist_new = hist_old;
        else
            hist_new = hist_sum[7:0];
        hist_we = s1_valid_reg && s1_in_roi_reg;

        s1_col_x = XW'(s1_col_reg);
        col_zero = (s1_col_reg == '0);
        lb_cnt   = col_zero ? 8'd0 : left_cnt_reg;
        lb_col   = col_zero ? 9'd0 : left_col_reg;
        rb_cnt   = col_zero ? 8'd0 : right_cnt_reg;
        rb_col   = col_zero ? cfg.right_search_start : right_col_reg;
        left_hit  = (s1_col_x < XW'(cfg.left_search_end)) && (hist_new > lb_cnt);
        right_hit = (s1_col_x >= XW'(cfg.right_search_start)) && (hist_new > rb_cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_cnt_reg  <= '0;
            left_col_reg  <= '0;
            right_cnt_reg <= '0;
            right_col_reg <= '0;
        end
        else if (s1_valid_reg && s1_last_row_reg)
        begin
            left_cnt_reg  <= left_hit ? hist_new : lb_cnt;
            left_col_reg  <= left_hit ? s1_col_x[8:0] : lb_col;
            right_cnt_reg <= right_hit ? hist_new : rb_cnt;
            right_col_reg <= right_hit ? s1_col_x[8:0] : rb_col;
        end
    end

    lhps_result u_result
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (p_valid_reg),
        .left_col     (left_col_reg),
        .right_col    (right_col_reg),
        .frame_center (cfg.frame_center),
        .near_step    (cfg.near_step),
        .far_step     (cfg.far_step),
        .res_valid    (res_valid),
        .res          (res)
    );

    lhps_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_item)
    );

    assign m_tdata = out_item;

endmodule
